[design/abpw_pkg.sv]
// Shared types and constants for the alpha blend pixel writer.
package abpw_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Frame registers are 9 bits, so row * width + column needs 18 bits.
    localparam int DIM_W = 9;
    localparam int IDX_W = 2 * DIM_W;
    localparam int OUT_IDX_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 9'd256;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        ST_OPAQUE = 2'd0,
        ST_BLEND  = 2'd1,
        ST_SKIP   = 2'd2,
        ST_OOB    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } pix_in_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } cmd_t;

endpackage

[design/abpw_front.sv]
// Front end: config registers, input beat capture, bounds check and index.
module abpw_front #(
    parameter int MAX_WIDTH  = abpw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abpw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [abpw_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  abpw_pkg::pix_in_t               in_data,
    input  logic                            clear_busy,
    output logic                            push,
    output abpw_pkg::cmd_t                  push_data,
    input  logic                            q_full
);
    import abpw_pkg::*;

    localparam logic [DIM_W-1:0] W_CLAMP =
        DIM_W'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_CLAMP =
        DIM_W'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic             stage_valid_reg;
    pix_in_t          stage_reg;

    logic [DIM_W-1:0] act_w;
    logic [DIM_W-1:0] act_h;
    logic             oob;
    logic [IDX_W-1:0] idx;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign push      = stage_valid_reg && !q_full;
    assign in_ready  = !clear_busy && (!stage_valid_reg || !q_full);
    assign accept    = in_valid && in_ready;

    assign act_w = (frame_width_reg > W_CLAMP) ? W_CLAMP : frame_width_reg;
    assign act_h = (frame_height_reg > H_CLAMP) ? H_CLAMP : frame_height_reg;

    always_comb
    begin
        oob = stage_reg.pos_x[15] || stage_reg.pos_y[15]
            || (stage_reg.pos_x[14:0] >= {6'b0, act_w})
            || (stage_reg.pos_y[14:0] >= {6'b0, act_h});
        idx = IDX_W'(stage_reg.pos_y[DIM_W-1:0]) * IDX_W'(act_w)
            + IDX_W'(stage_reg.pos_x[DIM_W-1:0]);

        push_data.red   = stage_reg.red;
        push_data.green = stage_reg.green;
        push_data.blue  = stage_reg.blue;
        push_data.alpha = stage_reg.alpha;
        push_data.idx   = oob ? '0 : idx;
        priority if (oob)
            push_data.status = ST_OOB;
        else if (stage_reg.alpha == ALPHA_CLEAR)
            push_data.status = ST_SKIP;
        else if (stage_reg.alpha == ALPHA_OPAQUE)
            push_data.status = ST_OPAQUE;
        else
            push_data.status = ST_BLEND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RESET;
            frame_height_reg <= FRAME_DIM_RESET;
            stage_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          frame_width_reg  <= frame_width_reg;
                endcase
            end
            if (accept)
                stage_valid_reg <= 1'b1;
            else if (push)
                stage_valid_reg <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= in_data;
    end

endmodule

[design/abpw_queue.sv]
// Short command queue between the front end and the store engine.
module abpw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  abpw_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output abpw_pkg::cmd_t  head
);
    import abpw_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[design/abpw_back.sv]
// Store engine: frame store, clearing pass, read-modify-write blend, result register.
module abpw_back #(
    parameter int MAX_WIDTH  = abpw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abpw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  abpw_pkg::cmd_t                  head,
    output logic                            pop,
    output logic                            clear_busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output abpw_pkg::status_t               out_status,
    output logic [abpw_pkg::OUT_IDX_W-1:0]  out_index,
    output logic [31:0]                     out_value
);
    import abpw_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX,
        S_WRITE
    } state_t;

    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [31:0]       store_mem [DEPTH];
    logic [31:0]       rd_data_reg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    cmd_t              cmd_reg, cmd_next;
    logic [2:0][15:0]  sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [OUT_IDX_W-1:0] out_index_reg, out_index_next;
    logic [31:0]       out_value_reg, out_value_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic              rd_en;
    logic [2:0][7:0]   new_ch;
    logic [31:0]       new_word;

    assign clear_busy = (state_reg == S_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_value  = out_value_reg;

    assign new_ch = {cmd_reg.red, cmd_reg.green, cmd_reg.blue};

    always_comb
    begin
        unique case (cmd_reg.status)
            ST_OPAQUE: new_word = {ALPHA_OPAQUE, new_ch};
            ST_BLEND:  new_word = {ALPHA_OPAQUE, div255(sum_reg[2]),
                                   div255(sum_reg[1]), div255(sum_reg[0])};
            ST_SKIP:   new_word = rd_data_reg;
            ST_OOB:    new_word = '0;
            default:   new_word = '0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        pop             = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    cmd_next   = head;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum_next[i] = 16'(new_ch[i]) * 16'(cmd_reg.alpha)
                        + 16'(rd_data_reg[8*i +: 8]) * 16'(ALPHA_OPAQUE - cmd_reg.alpha);
                end
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = cmd_reg.status;
                    out_index_next  = cmd_reg.idx[OUT_IDX_W-1:0];
                    out_value_next  = new_word;
                    mem_waddr       = ADDR_W'(cmd_reg.idx);
                    mem_wdata       = new_word;
                    mem_we          = (cmd_reg.status == ST_OPAQUE)
                                   || (cmd_reg.status == ST_BLEND);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cmd_reg        <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OOB;
            out_index_reg  <= '0;
            out_value_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cmd_reg        <= cmd_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
            out_value_reg  <= out_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= store_mem[ADDR_W'(head.idx)];
    end

    // The store is written only by the clearing pass or an opaque or blended item
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR)
            || (cmd_reg.status == ST_OPAQUE) || (cmd_reg.status == ST_BLEND))
        else $error("frame store written by a skip or out-of-bounds item");

    // No command leaves the queue before the clearing pass is done
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !pop)
        else $error("command popped during clearing pass");

    // Out-of-bounds results carry zero index and value
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OOB))
            |-> (out_index_reg == '0) && (out_value_reg == '0))
        else $error("out-of-bounds result with nonzero fields");

    // Written words always carry a full alpha byte
    a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == ST_OPAQUE) || (out_status_reg == ST_BLEND)))
            |-> (out_value_reg[31:24] == ALPHA_OPAQUE))
        else $error("stored word without opaque alpha");

    // A new result is loaded only when the previous one was taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_value_reg))
        else $error("result register overwritten while stalled");

endmodule

[design/alpha_blend_pixel_writer.sv]
// Top level: pixel write stream in, status stream out, frame size config.
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | pos_x, pos_y, red, green, blue, alpha
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | status, pixel_index, pixel_value
//  cfg       | in  | cfg_valid / cfg_ready           | cfg_index, cfg_data
//
// The front end takes one beat per cycle into a 4-entry command queue while it has room.
// The store engine takes each item through read, blend multiply and write on the
// single-ported frame store, and takes no new item until the last one is written.
// After reset a clearing pass zeroes all MAX_WIDTH * MAX_HEIGHT words of the store
// (65536 at the defaults); s_axis_tready stays low during it, cfg is taken.
// A stalled m_axis holds the result register; the queue fills, then s_axis stalls.
module alpha_blend_pixel_writer #(
    parameter int MAX_WIDTH  = abpw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abpw_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // pos_x, pos_y, red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status, pixel_index, pixel_value, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import abpw_pkg::*;

    pix_in_t              in_data;
    cmd_t                 push_data;
    cmd_t                 head;
    logic                 push;
    logic                 q_full;
    logic                 pop;
    logic                 head_valid;
    logic                 clear_busy;
    status_t              out_status;
    logic [OUT_IDX_W-1:0] out_index;
    logic [31:0]          out_value;

    assign in_data.pos_x = s_axis_tdata[15:0];
    assign in_data.pos_y = s_axis_tdata[31:16];
    assign in_data.red   = s_axis_tdata[39:32];
    assign in_data.green = s_axis_tdata[47:40];
    assign in_data.blue  = s_axis_tdata[55:48];
    assign in_data.alpha = s_axis_tdata[63:56];

    assign m_axis_tdata = {6'b0, out_value, out_index, out_status};

    abpw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (in_data),
        .clear_busy (clear_busy),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    abpw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    abpw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_index  (out_index),
        .out_value  (out_value)
    );

endmodule

[tb/sv/tb_alpha_blend_pixel_writer.sv]
// Self-checking testbench for the alpha blend pixel writer: frame store model and random writes.
`timescale 1ns / 100ps

module tb_alpha_blend_pixel_writer;
    import abpw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 163;
    localparam int DRAIN_WAIT  = 24;

    typedef struct packed {
        status_t     status;
        logic [15:0] idx;
        logic [31:0] value;
    } pix_result_t;

    // Frame-size rows carry width and height in the x and y columns.
    typedef struct packed {
        logic        is_cfg;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        typed;
        status_t     status;
        logic [15:0] idx;
        logic [31:0] value;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        //  cfg   x         y         r      g      b      a      typed  status     idx       value
        '{1'b1, 16'd256,  16'd256,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h0C, 8'h22, 8'h38, 8'h00, 1'b1, ST_SKIP,   16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h0C, 8'h22, 8'h38, 8'hFF, 1'b1, ST_OPAQUE, 16'h0000,
          32'hFF0C2238},
        '{1'b0, 16'd0,    16'd0,    8'hFF, 8'h00, 8'h80, 8'h80, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h01, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd255,  16'd255,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, ST_OPAQUE, 16'hFFFF,
          32'hFFFFFFFF},
        '{1'b0, 16'd255,  16'd255,  8'h00, 8'h00, 8'h00, 8'hFE, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd256,  16'd0,    8'h11, 8'h22, 8'h33, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd256,  8'h11, 8'h22, 8'h33, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'hFFFF, 16'd0,    8'h11, 8'h22, 8'h33, 8'h40, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'hFFFF, 8'h11, 8'h22, 8'h33, 8'h00, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'h8000, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b0, 16'd255,  16'd0,    8'hAA, 8'h55, 8'hF0, 8'h00, 1'b1, ST_SKIP,   16'h00FF, 32'h0},
        '{1'b1, 16'd0,    16'd256,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b1, 16'd511,  16'd1,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd255,  16'd0,    8'h01, 8'h02, 8'h03, 8'hFF, 1'b1, ST_OPAQUE, 16'h00FF,
          32'hFF010203},
        '{1'b0, 16'd0,    16'd1,    8'h01, 8'h02, 8'h03, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b1, 16'd1,    16'd511,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd255,  8'h80, 8'h80, 8'h80, 8'h7F, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd1,    16'd0,    8'h80, 8'h80, 8'h80, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0},
        '{1'b1, 16'd256,  16'd0,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_OPAQUE, 16'h0000, 32'h0},
        '{1'b0, 16'd0,    16'd0,    8'h9A, 8'hBC, 8'hDE, 8'hFF, 1'b1, ST_OOB,    16'h0000, 32'h0}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = CFG_FRAME_WIDTH;
    logic [8:0]  cfg_data      = '0;

    // Frame store copy, zero at start like the cleared hardware store.
    bit   [31:0] frame_mem [65536];
    logic [8:0]  frame_w = FRAME_DIM_RESET;
    logic [8:0]  frame_h = FRAME_DIM_RESET;
    logic [15:0] hot_x = '0;
    logic [15:0] hot_y = '0;

    pix_result_t pending_q [$];
    int miss_count = 0;
    int writes_sent = 0;
    int settings_used = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int tx_calm = 0;
    int rx_calm = 0;
    int rx_hold = 0;
    int cycles = 0;

    alpha_blend_pixel_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_dim(input logic [8:0] reg_val, input int cap);
        return (int'(reg_val) > cap) ? cap : int'(reg_val);
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] fresh, input logic [7:0] old,
                                               input logic [7:0] a);
        int unsigned acc;
        acc = int'(fresh) * int'(a) + int'(old) * (255 - int'(a));
        return 8'(acc / 255);
    endfunction

    // Apply one pixel write to the store copy and return what the block should report.
    function automatic pix_result_t blend_write(input pix_in_t p);
        pix_result_t res;
        int          ew;
        int          eh;
        int unsigned pos;
        logic [31:0] old;
        ew = eff_dim(frame_w, DEF_MAX_WIDTH);
        eh = eff_dim(frame_h, DEF_MAX_HEIGHT);
        res = '{ST_OOB, 16'h0, 32'h0};
        if (!p.pos_x[15] && !p.pos_y[15] && int'(p.pos_x) < ew && int'(p.pos_y) < eh)
        begin
            pos = int'(p.pos_y) * ew + int'(p.pos_x);
            old = frame_mem[pos];
            res.idx = 16'(pos);
            if (p.alpha == ALPHA_CLEAR)
            begin
                res.status = ST_SKIP;
                res.value  = old;
            end
            else if (p.alpha == ALPHA_OPAQUE)
            begin
                res.status = ST_OPAQUE;
                res.value  = {8'hFF, p.red, p.green, p.blue};
            end
            else
            begin
                res.status = ST_BLEND;
                res.value  = {8'hFF, mix_channel(p.red, old[23:16], p.alpha),
                              mix_channel(p.green, old[15:8], p.alpha),
                              mix_channel(p.blue, old[7:0], p.alpha)};
            end
            frame_mem[pos] = res.value;
        end
        status_seen[res.status]++;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic logic [8:0] rand_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 9'($urandom_range(1, 24));
        if (r < 8)
            return 9'($urandom_range(25, 256));
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic pix_in_t rand_pixel();
        pix_in_t     p;
        int          ew;
        int          eh;
        int          sel;
        logic [15:0] x;
        logic [15:0] y;
        ew = eff_dim(frame_w, DEF_MAX_WIDTH);
        eh = eff_dim(frame_h, DEF_MAX_HEIGHT);
        sel = $urandom_range(0, 99);
        x = (ew > 0) ? 16'($urandom_range(0, ew - 1)) : 16'h0;
        y = (eh > 0) ? 16'($urandom_range(0, eh - 1)) : 16'h0;
        if (sel >= 60 && sel < 75)
        begin
            // revisit the last pixel to hit the read-modify-write path back to back
            x = hot_x;
            y = hot_y;
        end
        else if (sel >= 75 && sel < 88)
        begin
            if ($urandom_range(0, 1))
                x = $urandom_range(0, 1) ? 16'(ew + $urandom_range(0, 3))
                                         : 16'hFFFF - 16'($urandom_range(0, 2));
            else
                y = $urandom_range(0, 1) ? 16'(eh + $urandom_range(0, 3))
                                         : 16'hFFFF - 16'($urandom_range(0, 2));
        end
        else if (sel >= 88)
        begin
            x = 16'($urandom());
            y = 16'($urandom());
        end
        hot_x = x;
        hot_y = y;
        p.pos_x = x;
        p.pos_y = y;
        p.red   = 8'($urandom());
        p.green = 8'($urandom());
        p.blue  = 8'($urandom());
        sel = $urandom_range(0, 3);
        p.alpha = (sel == 0) ? ALPHA_CLEAR : (sel == 1) ? ALPHA_OPAQUE : 8'($urandom());
        return p;
    endfunction

    function automatic void note_miss(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
        miss_count++;
        if (miss_count <= 10)
            $display("tb: mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got,
                     $realtime);
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_pixel(input pix_in_t p, input logic typed, input pix_result_t typed_res);
        int          gap;
        pix_result_t res;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = blend_write(p);
        pending_q.push_back(typed ? typed_res : res);
        writes_sent++;
    endtask

    // Drain first so the new frame size never lands under an item in flight.
    task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_w = w;
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_h = h;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Result side: check each beat and drive random backpressure.
    always @(posedge clk)
    begin
        pix_result_t want;
        int          g;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
                note_miss("result beat with nothing pending", 32'h0, m_axis_tdata[49:18]);
            else
            begin
                want = pending_q.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    note_miss("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
                if (m_axis_tdata[17:2] != want.idx)
                    note_miss("pixel_index", 32'(want.idx), 32'(m_axis_tdata[17:2]));
                if (m_axis_tdata[49:18] != want.value)
                    note_miss("pixel_value", want.value, m_axis_tdata[49:18]);
                if (m_axis_tdata[55:50] != '0)
                    note_miss("pad bits", 32'h0, 32'(m_axis_tdata[55:50]));
            end
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            g = pick_gap(rx_calm);
            m_axis_tready <= (g == 0);
            if (g > 0)
                rx_hold = g - 1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        pix_in_t    p;
        logic [8:0] w;
        logic [8:0] h;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].is_cfg)
                set_frame(DIRECTED[i].x[8:0], DIRECTED[i].y[8:0]);
            else
            begin
                p = '{DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].g, DIRECTED[i].r,
                      DIRECTED[i].y, DIRECTED[i].x};
                send_pixel(p, DIRECTED[i].typed,
                           '{DIRECTED[i].status, DIRECTED[i].idx, DIRECTED[i].value});
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:       begin w = 9'd256; h = 9'd256; end
                1:       begin w = 9'd1;   h = 9'd1;   end
                2:       begin w = 9'd511; h = 9'd511; end
                3:       begin w = 9'd0;   h = rand_dim(); end
                4:       begin w = 9'd2;   h = 9'd256; end
                default: begin w = rand_dim(); h = rand_dim(); end
            endcase
            set_frame(w, h);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_pixel(rand_pixel(), 1'b0, '{ST_OPAQUE, 16'h0, 32'h0});
        end
        s_axis_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_q.size() != 0)
            note_miss("results never delivered", 32'(pending_q.size()), 32'h0);

        $display("summary: %0d pixel writes (%0d directed) across %0d frame sizes, %0d cycles",
                 writes_sent, writes_sent - N_PHASES * PHASE_ITEMS, settings_used, cycles);
        $display("summary: opaque %0d, blended %0d, skipped %0d, out of bounds %0d, mismatches %0d",
                 status_seen[ST_OPAQUE], status_seen[ST_BLEND], status_seen[ST_SKIP],
                 status_seen[ST_OOB], miss_count);
        if (miss_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
